[rtl/ffbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffbp_pkg;

  localparam int WeightW = 16;
  localparam int TagW    = 16;
  localparam int BinNumW = 8;
  localparam int UsedW   = 9;

  typedef logic [WeightW-1:0] weight_t;
  typedef logic [TagW-1:0]    tag_t;

  // One input beat
  typedef struct packed {
    logic    new_run;
    weight_t item_weight;
    tag_t    item_tag;
  } in_item_t;

  // One result beat
  typedef struct packed {
    tag_t               placed_tag;
    logic [BinNumW-1:0] bin_number;
    logic               opened_bin;
    logic               too_heavy;
    logic               no_room;
    logic [UsedW-1:0]   bins_used;
  } out_item_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic    vld;
    logic    placed;
    weight_t weight;
  } tok_t;

endpackage

`default_nettype wire

[rtl/ffbp_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffbp_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  ffbp_pkg::weight_t  capacity,
  input  logic [CNT_W-1:0]   open_bins,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_idx,
  input  ffbp_pkg::weight_t  wr_data,
  input  ffbp_pkg::tok_t     tok_in,
  input  logic [IDX_W-1:0]   bin_in,
  output ffbp_pkg::tok_t     tok_out,
  output logic [IDX_W-1:0]   bin_out
);
  import ffbp_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(IDX);

  weight_t          load;
  logic             bin_open;
  logic [WeightW:0] sum;
  logic             fits;

  // fit test for this bin
  assign bin_open = MyCnt < open_bins;
  assign sum      = {1'b0, load} + {1'b0, tok_in.weight};
  assign fits     = tok_in.vld && !tok_in.placed && bin_open && (sum <= {1'b0, capacity});

  // bin load: cleared at reset for bin zero, written on open/clear, bumped on a fit
  always_ff @(posedge clk) begin
    if (rst && (IDX == 0)) begin
      load <= '0;
    end else if (wr_en && (wr_idx == MyIdx)) begin
      load <= wr_data;
    end else if (fits) begin
      load <= sum[WeightW-1:0];
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.placed <= tok_in.placed | fits;
    tok_out.weight <= tok_in.weight;
    bin_out        <= fits ? MyIdx : bin_in;
  end

endmodule

`default_nettype wire

[rtl/first_fit_bin_packer_top.sv]
// An accepted input beat is registered as the launch token and walks the row
// of MAX_BINS bin cells one cell per cycle; the end stage settles it into the
// result register. in_stall holds off new input until that result moves on.
// A finished result may wait in the output register while the next item runs.
// Reset (rst, synchronous): capacity 65535, one open bin with load zero,
// no item in flight, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_bin_packer_top #(
  parameter int MAX_BINS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  ffbp_pkg::weight_t   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffbp_pkg::out_item_t out_data
);
  import ffbp_pkg::*;

  localparam int IdxW = $clog2(MAX_BINS);
  localparam int CntW = $clog2(MAX_BINS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BINS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  weight_t         capacity;
  logic [CntW-1:0] open_bins;
  logic [CntW-1:0] open_bins_next;
  logic            busy;
  tag_t            tag_q;
  logic            done_valid;
  out_item_t       done;
  out_item_t       done_next;
  tok_t            tok_head;

  tok_t            tok     [0:MAX_BINS];
  logic [IdxW-1:0] tok_bin [0:MAX_BINS];

  logic            in_acc;
  logic            end_vld;
  tok_t            end_tok;
  logic            end_open;
  logic            move_out;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  weight_t         wr_data;
  logic [IdxW+BinNumW-1:0] bin_ext;
  logic [CntW+UsedW-1:0]   used_ext;
  logic [IdxW-1:0]         bin_sel;

  assign in_stall   = busy;
  assign in_acc     = in_valid && !busy;
  assign tok[0]     = tok_head;
  assign tok_bin[0] = '0;
  assign end_tok    = tok[MAX_BINS];
  assign end_vld    = end_tok.vld;
  assign end_open   = !end_tok.placed && (open_bins < CntMax);
  assign move_out   = done_valid && (!out_valid || !out_stall);

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // bin write port: clear bin zero on a new run, load a freshly opened bin
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = '0;
    if (in_acc && in_data.new_run) begin
      wr_en = 1'b1;
    end else if (end_vld && end_open) begin
      wr_en   = 1'b1;
      wr_idx  = open_bins[IdxW-1:0];
      wr_data = end_tok.weight;
    end
  end

  // open bin count
  always_comb begin
    open_bins_next = open_bins;
    if (in_acc && in_data.new_run) begin
      open_bins_next = CntOne;
    end else if (end_vld && end_open) begin
      open_bins_next = open_bins + CntOne;
    end
  end

  // result of the finished search
  always_comb begin
    if (end_tok.placed) begin
      bin_sel = tok_bin[MAX_BINS];
    end else if (end_open) begin
      bin_sel = open_bins[IdxW-1:0];
    end else begin
      bin_sel = '0;
    end
    bin_ext  = {{BinNumW{1'b0}}, bin_sel};
    used_ext = {{UsedW{1'b0}}, open_bins_next};
    done_next.placed_tag = tag_q;
    done_next.bin_number = bin_ext[BinNumW-1:0];
    done_next.opened_bin = end_open;
    done_next.too_heavy  = end_tok.weight > capacity;
    done_next.no_room    = !end_tok.placed && !end_open;
    done_next.bins_used  = used_ext[UsedW-1:0];
  end

  // launch token, control and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_bins    <= CntOne;
      busy         <= 1'b0;
      done_valid   <= 1'b0;
      out_valid    <= 1'b0;
      tok_head.vld <= 1'b0;
    end else begin
      open_bins    <= open_bins_next;
      tok_head.vld <= in_acc;
      if (in_acc) begin
        busy <= 1'b1;
      end else if (move_out) begin
        busy <= 1'b0;
      end
      if (end_vld) begin
        done_valid <= 1'b1;
      end else if (move_out) begin
        done_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    tok_head.placed <= 1'b0;
    tok_head.weight <= in_data.item_weight;
    if (in_acc) begin
      tag_q <= in_data.item_tag;
    end
    if (end_vld) begin
      done <= done_next;
    end
    if (move_out) begin
      out_data <= done;
    end
  end

  // row of bin cells
  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    ffbp_cell #(
      .IDX_W (IdxW),
      .CNT_W (CntW),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .capacity  (capacity),
      .open_bins (open_bins),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .tok_in    (tok[i]),
      .bin_in    (tok_bin[i]),
      .tok_out   (tok[i+1]),
      .bin_out   (tok_bin[i+1])
    );
  end

endmodule

`default_nettype wire

[rtl/ffbp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffbp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input ffbp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ffbp_pkg::out_item_t out_data
);
  import ffbp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // one item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a dropped item reports bin zero and opens nothing
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_room |-> !out_data.opened_bin && (out_data.bin_number == '0))
    else $error("dropped item shows a bin");

  // an overweight item never lands in an existing bin
  a_heavy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_heavy |-> out_data.opened_bin || out_data.no_room)
    else $error("overweight item placed into an open bin");

endmodule

bind first_fit_bin_packer_top ffbp_checker u_ffbp_checker (.*);

`default_nettype wire

[verif/tb_first_fit_bin_packer_top.sv]
`timescale 1ns / 1ps

module tb_first_fit_bin_packer_top;
  import ffbp_pkg::*;

  localparam int BINS = 256;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned MaxWeight = 65535;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  weight_t   cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  first_fit_bin_packer_top #(
    .MAX_BINS(BINS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Packing state mirrored on the testbench side
  weight_t     capacity;
  weight_t     bin_load [BINS];
  int unsigned bins_open;

  out_item_t   pending_placements[$];

  // Run control and tallies
  bit          quiet;          // no idling on either side
  int unsigned hold_request;   // receiver hold-off, in cycles
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned bins_opened_seen;
  int unsigned heavy_seen;
  int unsigned dropped_seen;
  int unsigned mismatches;
  int unsigned failures;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // First-fit placement of one item; updates the mirrored bins
  function automatic out_item_t place_item(input in_item_t it);
    out_item_t   res;
    bit [16:0]   sum;
    bit          found;
    int unsigned chosen;
    res    = '0;
    found  = 1'b0;
    chosen = 0;
    if (it.new_run) begin
      bin_load[0] = '0;
      bins_open   = 1;
    end
    for (int j = 0; j < BINS; j++) begin
      if (!found && j < bins_open) begin
        sum = bin_load[j] + it.item_weight;
        if (sum <= {1'b0, capacity}) begin
          bin_load[j] = sum[15:0];
          chosen      = j;
          found       = 1'b1;
        end
      end
    end
    if (!found) begin
      if (bins_open < BINS) begin
        chosen           = bins_open;
        bin_load[chosen] = it.item_weight;
        bins_open++;
        res.opened_bin   = 1'b1;
      end else begin
        res.no_room = 1'b1;
      end
    end
    res.placed_tag = it.item_tag;
    res.bin_number = chosen[7:0];
    res.too_heavy  = (it.item_weight > capacity);
    res.bins_used  = bins_open[8:0];
    return res;
  endfunction

  // Compare one result beat against the oldest expectation
  function automatic void check_placement(input out_item_t got);
    out_item_t want;
    bit        ok;
    if (pending_placements.size() == 0) begin
      failures++;
      if (mismatches < 10)
        $display("unexpected result beat: tag %h bin %0d", got.placed_tag, got.bin_number);
      mismatches++;
      return;
    end
    want = pending_placements.pop_front();
    beats_checked++;
    bins_opened_seen += want.opened_bin;
    heavy_seen       += want.too_heavy;
    dropped_seen     += want.no_room;
    ok = (got.placed_tag === want.placed_tag) && (got.bin_number === want.bin_number) &&
         (got.opened_bin === want.opened_bin) && (got.too_heavy === want.too_heavy) &&
         (got.no_room === want.no_room) && (got.bins_used === want.bins_used);
    if (!ok) begin
      failures++;
      if (mismatches < 10) begin
        $display("mismatch at beat %0d: want tag %h bin %0d open %b heavy %b drop %b used %0d",
                 beats_checked, want.placed_tag, want.bin_number, want.opened_bin,
                 want.too_heavy, want.no_room, want.bins_used);
        $display("                      got  tag %h bin %0d open %b heavy %b drop %b used %0d",
                 got.placed_tag, got.bin_number, got.opened_bin, got.too_heavy,
                 got.no_room, got.bins_used);
      end
      mismatches++;
    end
  endfunction

  // Result side: check accepted beats, drive stall (random or held off)
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_placement(out_data);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 24);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("run did not finish within %0d cycles, %0d results outstanding",
               CycleLimit, pending_placements.size());
      $display("[first_fit_bin_packer_top] ERROR");
      $finish;
    end
  end

  function automatic in_item_t mk_item(input bit nr, input int unsigned w, input int unsigned tag);
    in_item_t it;
    it.new_run     = nr;
    it.item_weight = weight_t'(w);
    it.item_tag    = tag_t'(tag);
    return it;
  endfunction

  // Offer one beat, with an occasional random gap first; valid stays high after
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 24) gap = $urandom_range(1, 300);
    while (gap != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap--;
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_placements.insert(pending_placements.size(), place_item(it));
    items_sent++;
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  // Only called with no beat in flight
  task automatic set_capacity(input int unsigned cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= weight_t'(cap);
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity  = weight_t'(cap);
  endtask

  function automatic weight_t pick_weight(input int unsigned cap);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 10) return weight_t'(cap);
    if (sel < 14) return (cap < MaxWeight) ? weight_t'(cap + 1) : weight_t'(MaxWeight);
    if (sel < 22) return weight_t'($urandom);
    if (sel < 60) return weight_t'($urandom_range(0, cap / 2));
    return weight_t'($urandom_range(cap / 4, cap));
  endfunction

  // Reset capacity: zero and full-scale weights, exact fill of a bin
  task automatic test_default_capacity();
    send_item(mk_item(1'b0, 0, 16'h0000));
    send_item(mk_item(1'b0, MaxWeight, 16'hFFFF));
    send_item(mk_item(1'b0, 1, 16'h5A5A));
    send_item(mk_item(1'b0, MaxWeight, 16'hA5A5));
    send_item(mk_item(1'b1, MaxWeight, 16'h0001));
    hold_input();
    wait_drain();
  endtask

  // Zero capacity: only weightless items share a bin
  task automatic test_zero_capacity();
    set_capacity(0);
    send_item(mk_item(1'b1, 0, 16'h1000));
    send_item(mk_item(1'b0, 1, 16'h1001));
    send_item(mk_item(1'b0, 0, 16'h1002));
    send_item(mk_item(1'b0, MaxWeight, 16'h1003));
    hold_input();
    wait_drain();
  endtask

  // Sums landing on and just over the capacity, overweight opener
  task automatic test_exact_fit();
    set_capacity(100);
    send_item(mk_item(1'b1, 60, 16'h2000));
    send_item(mk_item(1'b0, 40, 16'h2001));
    send_item(mk_item(1'b0, 41, 16'h2002));
    send_item(mk_item(1'b0, 59, 16'h2003));
    send_item(mk_item(1'b0, 101, 16'h2004));
    send_item(mk_item(1'b0, 100, 16'h2005));
    send_item(mk_item(1'b0, 0, 16'h2006));
    hold_input();
    wait_drain();
  endtask

  // Open every bin, then late fits, drops (plain and overweight), fresh run
  task automatic test_bins_exhausted();
    set_capacity(10);
    send_item(mk_item(1'b1, 10, 16'h3000));
    for (int i = 1; i < BINS; i++) send_item(mk_item(1'b0, 7, 16'h3000 + i));
    send_item(mk_item(1'b0, 3, 16'h3F00));
    send_item(mk_item(1'b0, 4, 16'h3F01));
    send_item(mk_item(1'b0, 11, 16'h3F02));
    send_item(mk_item(1'b0, 0, 16'h3F03));
    send_item(mk_item(1'b1, 4, 16'h3F04));
    hold_input();
    wait_drain();
  endtask

  // Long receiver hold-off while input keeps coming: input must back up
  task automatic test_output_backpressure();
    set_capacity(1000);
    hold_request = 1500;
    send_item(mk_item(1'b1, $urandom_range(0, 1000), $urandom));
    for (int i = 0; i < 7; i++)
      send_item(mk_item(1'b0, $urandom_range(0, 1000), $urandom));
    hold_input();
    wait_drain();
  endtask

  // Random packing runs: new_run at the head of each run, a few stray ones
  task automatic test_random_runs(input int unsigned cap, input int unsigned n_items);
    int unsigned sent;
    int unsigned run_left;
    in_item_t    it;
    sent     = 0;
    run_left = 0;
    set_capacity(cap);
    while (sent < n_items) begin
      if (run_left == 0) begin
        run_left   = ($urandom_range(0, 99) < 4) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
        it.new_run = 1'b1;
      end else begin
        it.new_run = ($urandom_range(0, 99) < 3);
      end
      it.item_weight = pick_weight(cap);
      it.item_tag    = tag_t'($urandom);
      send_item(it);
      run_left--;
      sent++;
    end
    hold_input();
    wait_drain();
  endtask

  initial begin
    clk              = 1'b0;
    quiet            = 1'b0;
    hold_request     = 0;
    hold_left        = 0;
    cycle_count      = 0;
    items_sent       = 0;
    beats_checked    = 0;
    bins_opened_seen = 0;
    heavy_seen       = 0;
    dropped_seen     = 0;
    mismatches       = 0;
    failures         = 0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    capacity    = weight_t'(MaxWeight);
    bin_load[0] = '0;
    bins_open   = 1;

    test_default_capacity();
    test_zero_capacity();
    test_exact_fit();
    test_bins_exhausted();
    test_output_backpressure();
    test_random_runs(MaxWeight, 210);
    test_random_runs(0, 210);
    test_random_runs(1, 210);
    test_random_runs($urandom_range(2, 255), 210);
    quiet = 1'b1;
    test_random_runs(1000, 210);
    quiet = 1'b0;
    test_random_runs($urandom_range(256, 65534), 210);
    test_random_runs(40000, 210);

    // Let any stray beat show up before the verdict
    repeat (BINS + 8) @(posedge clk);
    failures += pending_placements.size();

    $display("%0d items placed through capacities 0, 1, 10, 100 .. 65535; %0d results checked",
             items_sent, beats_checked);
    $display("%0d new bins, %0d overweight, %0d dropped for lack of bins; %0d mismatches",
             bins_opened_seen, heavy_seen, dropped_seen, mismatches);
    if (failures == 0) begin
      $display("[first_fit_bin_packer_top] OK");
    end else begin
      $display("[first_fit_bin_packer_top] ERROR");
    end
    $finish;
  end

endmodule
